// File: rtl/core/icrb_pkg.sv
package icrb_pkg;

   localparam int PIXEL_W      = 8;
   localparam int KSIZE_W      = 3;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int WREG_W       = 60;
   localparam int WREG_COUNT   = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int MAX_HEIGHT   = 4096;
   localparam int OUT_ROW_W    = 12;
   localparam int IN_ROW_W     = 13;
   localparam int HALF_W       = 2;

   // Line memory is split into row slots (row modulo 8) and column banks
   // (column modulo 8), so that any 5x5 window hits each bank at most once.
   localparam int ROW_BANKS  = 8;
   localparam int COL_BANKS  = 8;
   localparam int BANK_SEL_W = 3;

   localparam logic [KSIZE_W-1:0]      KSIZE_RESET  = 3'd3;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;
   localparam logic [PIXEL_W-1:0]      PIXEL_MAX    = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_SIZE  = 3'd0,
      CSR_IMAGE_WIDTH  = 3'd1,
      CSR_IMAGE_HEIGHT = 3'd2,
      CSR_WEIGHT_ROW_0 = 3'd3,
      CSR_WEIGHT_ROW_1 = 3'd4,
      CSR_WEIGHT_ROW_2 = 3'd5,
      CSR_WEIGHT_ROW_3 = 3'd6,
      CSR_WEIGHT_ROW_4 = 3'd7
   } csr_index_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_FLUSH = 1'b1
   } req_mode_type;

endpackage

// File: rtl/core/image_convolution_replicate_border_top.sv
// Streaming KxK convolution (K = 1, 3 or 5) of 8-bit grayscale pixels with
// replicated image borders, rounded half up and saturated to 0..255.
// Request channel (req_*): one pixel per request in raster order, tuser = 0;
// after the frame's last pixel send flush requests (tuser = 1) until the
// result with rsp_tlast high has come out. A flush inside the frame is dropped.
// Result channel (rsp_*): one filtered pixel per result, tlast on the frame's
// final one. Result m is caused by request m + (K/2)*W + K/2 and enters the
// output register after passing the stage 1, stage 2 and stage 3 registers;
// from there it can be taken while rsp_tready is high.
// Throughput: one request per cycle when not stalled. Each request writes one pixel into the
// banked line memory and reads a whole window in the same cycle (eight column
// banks, one read each); a captured write is forwarded to the window. The
// window then passes multiply, row-sum and final-sum stages.
// Reset: counters clear, registers return to K=3, 512x512, all weights zero.
// The line memory is not cleared; only pixels already written are read.
// Stall: while a result waits with rsp_tready low, the whole pipeline holds
// and req_tready is low; nothing is lost or repeated.
// Configuration (csr_*): write only while no frame is in flight.
module image_convolution_replicate_border_top #(
   parameter int MAX_KERNEL  = 5,
   parameter int MAX_WIDTH   = 1024,
   parameter int WEIGHT_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [icrb_pkg::PIXEL_W-1:0]          req_tdata,  // [7:0] pixel_in
   input  logic                                  req_tuser,  // [0] mode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [icrb_pkg::PIXEL_W-1:0]          rsp_tdata,  // [7:0] filtered_pixel
   output logic                                  rsp_tlast,
   input  logic                                  csr_wr_en,
   input  logic [icrb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [icrb_pkg::WREG_W-1:0]           csr_wdata
);
   import icrb_pkg::*;

   localparam int K_MIN5     = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;
   localparam int KW         = K_MIN5 - (((K_MIN5 % 2) == 0) ? 1 : 0);
   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int PW         = $clog2(MAX_WIDTH * (MAX_HEIGHT + 4));
   localparam int FRAC       = WEIGHT_BITS - 2;
   localparam int PROD_W     = PIXEL_W + WEIGHT_BITS;
   localparam int ROWSUM_W   = PROD_W + 3;
   localparam int SUM_W      = PROD_W + 5;
   localparam int BANK_DEPTH = (MAX_WIDTH + COL_BANKS - 1) / COL_BANKS;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   // configuration registers
   logic [KSIZE_W-1:0]      kernel_size_ff;
   logic [WIDTH_REG_W-1:0]  image_width_ff;
   logic [HEIGHT_REG_W-1:0] image_height_ff;
   logic [WREG_W-1:0]       weight_row_ff [WREG_COUNT];

   // effective settings, refreshed every cycle
   logic [KSIZE_W-1:0] k_ff, k_in;
   logic [HALF_W-1:0]  half_ff, half_in;
   logic [WW-1:0]      w_ff, w_in;
   logic [IN_ROW_W-1:0] h_ff, h_in;
   logic [PW-1:0]      total_ff, total_in;
   logic [PW-1:0]      lag_ff, lag_in;

   // position counters
   logic [CW-1:0]        in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [PW-1:0]        in_pos_ff, in_pos_in;
   logic [CW-1:0]        out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic [PW-1:0]        out_pos_ff, out_pos_in;

   logic en, accept, in_frame, active, wr_en, past_lag, out_bad, is_last, produce, clear;

   logic [BANK_SEL_W-1:0] nr_lo [KW];
   logic [BANK_SEL_W-1:0] nc_lo [KW];
   logic [CW-1:0]         nc [KW];
   logic [AW-1:0]         raddr [COL_BANKS];
   logic [BANK_SEL_W-1:0] wcb, wrb;
   logic [AW-1:0]         waddr;
   logic                  fwd_hit;

   logic [ROW_BANKS-1:0][PIXEL_W-1:0] rd_data [COL_BANKS];

   // stage 1: memory data present
   logic                  s1_valid_ff, s1_last_ff;
   logic [KSIZE_W-1:0]    s1_k_ff;
   logic [BANK_SEL_W-1:0] s1_nr_lo_ff [KW];
   logic [BANK_SEL_W-1:0] s1_nc_lo_ff [KW];
   logic                  fwd_valid_ff;
   logic [BANK_SEL_W-1:0] fwd_cb_ff, fwd_rb_ff;
   logic [PIXEL_W-1:0]    fwd_px_ff;

   logic [PROD_W-1:0]     prod [KW][KW];

   // stage 2: products
   logic                  s2_valid_ff, s2_last_ff;
   logic [PROD_W-1:0]     prod_ff [KW][KW];
   logic [ROWSUM_W-1:0]   row_sum [KW];

   // stage 3: row sums
   logic                  s3_valid_ff, s3_last_ff;
   logic [ROWSUM_W-1:0]   row_sum_ff [KW];
   logic [PIXEL_W-1:0]    result;

   // output register
   logic                  rsp_tvalid_ff, rsp_tlast_ff;
   logic [PIXEL_W-1:0]    rsp_tdata_ff;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff  <= KSIZE_RESET;
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         for (int i = 0; i < WREG_COUNT; i++) begin
            weight_row_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KERNEL_SIZE:  kernel_size_ff   <= csr_wdata[KSIZE_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff   <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff  <= csr_wdata[HEIGHT_REG_W-1:0];
            CSR_WEIGHT_ROW_0: weight_row_ff[0] <= csr_wdata;
            CSR_WEIGHT_ROW_1: weight_row_ff[1] <= csr_wdata;
            CSR_WEIGHT_ROW_2: weight_row_ff[2] <= csr_wdata;
            CSR_WEIGHT_ROW_3: weight_row_ff[3] <= csr_wdata;
            CSR_WEIGHT_ROW_4: weight_row_ff[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturate the settings into their legal ranges; an even K drops to the
   // odd size below it. Take the value being written (or the reset value) so
   // that the effective settings change at the same edge as the register.
   always_comb begin
      int k, w, h;
      logic [KSIZE_W-1:0]      ks;
      logic [WIDTH_REG_W-1:0]  ws;
      logic [HEIGHT_REG_W-1:0] hs;
      ks = kernel_size_ff;
      ws = image_width_ff;
      hs = image_height_ff;
      if (reset) begin
         ks = KSIZE_RESET;
         ws = WIDTH_RESET;
         hs = HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KERNEL_SIZE:  ks = csr_wdata[KSIZE_W-1:0];
            CSR_IMAGE_WIDTH:  ws = csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: hs = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
      k = int'(ks);
      if (k > KW) k = KW;
      if (k == 0) k = 1;
      if ((k % 2) == 0) k = k - 1;
      w = int'(ws);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(hs);
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      k_in     = KSIZE_W'(k);
      half_in  = HALF_W'(k / 2);
      w_in     = WW'(w);
      h_in     = IN_ROW_W'(h);
      total_in = PW'(w * h);
      lag_in   = PW'((k / 2) * w + (k / 2));
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      half_ff  <= half_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      total_ff <= total_in;
      lag_ff   <= lag_in;
   end

   // ---------------------------------------------------------------------
   // Stage 0: accept request, advance counters, address the window
   // ---------------------------------------------------------------------
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   always_comb begin
      in_frame = in_pos_ff < total_ff;
      // drop a flush that arrives inside the frame
      active   = accept && !(in_frame && (req_tuser == MODE_FLUSH));
      wr_en    = active && in_frame;
      past_lag = in_pos_ff >= lag_ff;
      out_bad  = (WW'(out_col_ff) >= w_ff) || (out_pos_ff >= total_ff);
      is_last  = out_pos_ff == (total_ff - 1'b1);
      produce  = active && past_lag && !out_bad;
      clear    = active && past_lag && (out_bad || is_last);
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_pos_in  = in_pos_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_pos_in = out_pos_ff;
      if (active) begin
         in_pos_in = in_pos_ff + 1'b1;
         if (WW'(in_col_ff) == (w_ff - 1'b1)) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (clear) begin
            in_col_in  = '0;
            in_row_in  = '0;
            in_pos_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            out_pos_in = '0;
         end else if (past_lag) begin
            out_pos_in = out_pos_ff + 1'b1;
            if (WW'(out_col_ff) == (w_ff - 1'b1)) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_pos_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_pos_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_pos_ff  <= in_pos_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_pos_ff <= out_pos_in;
      end
   end

   // Clamp window rows and columns to the image: the border replicates.
   always_comb begin
      int r, c;
      for (int d = 0; d < KW; d++) begin
         r = int'(out_row_ff) + d - int'(half_ff);
         if (r < 0) r = 0;
         if (r > int'(h_ff) - 1) r = int'(h_ff) - 1;
         nr_lo[d] = BANK_SEL_W'(r);
         c = int'(out_col_ff) + d - int'(half_ff);
         if (c < 0) c = 0;
         if (c > int'(w_ff) - 1) c = int'(w_ff) - 1;
         nc[d]    = CW'(c);
         nc_lo[d] = BANK_SEL_W'(c);
      end
   end

   // Window columns are consecutive, so each column bank is hit at most once.
   always_comb begin
      for (int b = 0; b < COL_BANKS; b++) begin
         raddr[b] = '0;
         for (int d = 0; d < KW; d++) begin
            if (nc_lo[d] == BANK_SEL_W'(b)) raddr[b] = AW'(nc[d] >> BANK_SEL_W);
         end
      end
   end

   assign wcb     = BANK_SEL_W'(in_col_ff);
   assign wrb     = BANK_SEL_W'(in_row_ff);
   assign waddr   = AW'(in_col_ff >> BANK_SEL_W);
   // the pixel written now may be part of this window: forward it
   assign fwd_hit = wr_en && (raddr[wcb] == waddr);

   for (genvar cb = 0; cb < COL_BANKS; cb++) begin : g_bank
      logic [ROW_BANKS-1:0][PIXEL_W-1:0] mem [BANK_DEPTH];
      logic [ROW_BANKS-1:0][PIXEL_W-1:0] rd_ff;
      always_ff @(posedge clock) begin
         if (wr_en && (wcb == BANK_SEL_W'(cb))) mem[waddr][wrb] <= req_tdata;
         if (en) rd_ff <= mem[raddr[cb]];
      end
      assign rd_data[cb] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= produce;
         fwd_valid_ff <= fwd_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_last_ff <= is_last;
         s1_k_ff    <= k_ff;
         fwd_cb_ff  <= wcb;
         fwd_rb_ff  <= wrb;
         fwd_px_ff  <= req_tdata;
         for (int d = 0; d < KW; d++) begin
            s1_nr_lo_ff[d] <= nr_lo[d];
            s1_nc_lo_ff[d] <= nc_lo[d];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: pick window pixels from the banks, multiply by weights
   // ---------------------------------------------------------------------
   always_comb begin
      logic [PIXEL_W-1:0]     px;
      logic [63:0]            wrow;
      logic [WEIGHT_BITS-1:0] wt;
      for (int dy = 0; dy < KW; dy++) begin
         for (int dx = 0; dx < KW; dx++) begin
            px = rd_data[s1_nc_lo_ff[dx]][s1_nr_lo_ff[dy]];
            if (fwd_valid_ff && (s1_nc_lo_ff[dx] == fwd_cb_ff)
                && (s1_nr_lo_ff[dy] == fwd_rb_ff)) px = fwd_px_ff;
            wrow = 64'(weight_row_ff[dy]);
            wt   = ((dx * WEIGHT_BITS) < 64) ? WEIGHT_BITS'(wrow >> (dx * WEIGHT_BITS)) : '0;
            if ((dy < int'(s1_k_ff)) && (dx < int'(s1_k_ff)))
               prod[dy][dx] = PROD_W'(px) * PROD_W'(wt);
            else
               prod[dy][dx] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_last_ff <= s1_last_ff;
         prod_ff    <= prod;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: sum each kernel row
   // ---------------------------------------------------------------------
   always_comb begin
      for (int dy = 0; dy < KW; dy++) begin
         row_sum[dy] = '0;
         for (int dx = 0; dx < KW; dx++) begin
            row_sum[dy] = row_sum[dy] + ROWSUM_W'(prod_ff[dy][dx]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_last_ff <= s2_last_ff;
         row_sum_ff <= row_sum;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: total, round half up, saturate
   // ---------------------------------------------------------------------
   always_comb begin
      logic [SUM_W-1:0] acc;
      logic [SUM_W-1:0] rnd;
      acc = '0;
      for (int dy = 0; dy < KW; dy++) begin
         acc = acc + SUM_W'(row_sum_ff[dy]);
      end
      rnd = (acc + (SUM_W'(1) << (FRAC - 1))) >> FRAC;
      result = (rnd > SUM_W'(PIXEL_MAX)) ? PIXEL_MAX : PIXEL_W'(rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= result;
         rsp_tlast_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_produce_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      produce |=> s1_valid_ff)
      else $error("accepted request with a result did not enter the pipeline");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while a result is stalled");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(s3_valid_ff) && $stable(s2_valid_ff)))
      else $error("pipeline moved during an output stall");

endmodule

// File: tb/image_convolution_replicate_border_top_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the streaming KxK border-replicating convolution.
// A behavioural predictor runs alongside the block: every accepted request is
// pushed through it, and every result it forecasts is queued. Each result
// taken from the block is compared with the oldest queued one.
module image_convolution_replicate_border_top_tb;
   import icrb_pkg::*;

   localparam int HIST_DEPTH = 4 * 1024 + 5;   // (MAX_KERNEL-1)*MAX_WIDTH + MAX_KERNEL
   localparam int STALL_LIMIT = 3000;          // cycles with nothing accepted
   localparam int PIPE_DRAIN = 12;             // settling wait after the queue empties, covering the pipeline registers

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } filtered_t;

   // One directed step: either a register write or a request, with the
   // result typed in where it is obvious.
   typedef struct {
      bit                 is_csr;
      csr_index_type      index;
      logic [WREG_W-1:0]  value;
      req_mode_type       mode;
      logic [PIXEL_W-1:0] pixel;
      bit                 typed;
      filtered_t          result;
   } step_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata;   // [7:0] pixel_in
   logic                   req_tuser;   // [0] mode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [PIXEL_W-1:0]     rsp_tdata;   // [7:0] filtered_pixel
   logic                   rsp_tlast;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [WREG_W-1:0]      csr_wdata;

   image_convolution_replicate_border_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state: register copies, pixel history and raster counters
   logic [KSIZE_W-1:0]      k_reg;
   logic [WIDTH_REG_W-1:0]  w_reg;
   logic [HEIGHT_REG_W-1:0] h_reg;
   logic [WREG_W-1:0]       weight_reg [WREG_COUNT];
   logic [PIXEL_W-1:0]      pixel_history [HIST_DEPTH];
   int                      in_col, in_row, out_col, out_row;

   filtered_t  pending_results [$];
   int         error_count;
   bit         quiet;        // when set, neither side idles
   bit         cur_typed;
   filtered_t  cur_result;
   step_t      directed [$];
   int         stall_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int eff_kernel();
      int k;
      k = k_reg;
      if (k > 5) k = 5;
      if (k == 0) k = 1;
      if (k % 2 == 0) k--;
      return k;
   endfunction

   function automatic int eff_width();
      if (w_reg == 0) return 1;
      return (w_reg > 1024) ? 1024 : int'(w_reg);
   endfunction

   function automatic int eff_height();
      if (h_reg == 0) return 1;
      return (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_reg);
   endfunction

   function automatic int clamp(int v, int hi);
      if (v < 0) return 0;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void clear_raster();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // Advance the raster counters by one request and work out the filtered
   // pixel it releases, if any.
   function automatic void convolve_request(input logic mode, input logic [7:0] pixel,
                                            output bit produced, output filtered_t res);
      int  k, half, w, h, total, lag, pos, m, nr, nc;
      longint acc;
      longint rounded;
      k = eff_kernel();
      half = k / 2;
      w = eff_width();
      h = eff_height();
      total = w * h;
      lag = half * w + half;
      pos = in_row * w + in_col;
      produced = 0;
      res = '0;
      if (pos < total) begin
         if (mode == MODE_FLUSH) return;
         pixel_history[pos % HIST_DEPTH] = pixel;
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (pos < lag) return;
      m = out_row * w + out_col;
      if (out_col >= w || m >= total) begin
         clear_raster();
         return;
      end
      acc = 0;
      for (int dy = 0; dy < k; dy++) begin
         nr = clamp(out_row + dy - half, h - 1);
         for (int dx = 0; dx < k; dx++) begin
            nc = clamp(out_col + dx - half, w - 1);
            acc += longint'(weight_reg[dy][dx*12 +: 12])
                   * longint'(pixel_history[(nr * w + nc) % HIST_DEPTH]);
         end
      end
      rounded = (acc + 512) >>> 10;
      res.pixel = (rounded > 255) ? PIXEL_MAX : rounded[7:0];
      res.last = (m == total - 1);
      produced = 1;
      if (res.last) begin
         clear_raster();
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Track writes and handshakes at the rising edge
   always @(posedge clock) begin
      bit        produced;
      filtered_t res;
      filtered_t want;
      if (reset) begin
         k_reg <= KSIZE_RESET;
         w_reg <= WIDTH_RESET;
         h_reg <= HEIGHT_RESET;
         for (int i = 0; i < WREG_COUNT; i++) weight_reg[i] <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) pixel_history[i] = '0;
         clear_raster();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_KERNEL_SIZE:  k_reg <= csr_wdata[KSIZE_W-1:0];
               CSR_IMAGE_WIDTH:  w_reg <= csr_wdata[WIDTH_REG_W-1:0];
               CSR_IMAGE_HEIGHT: h_reg <= csr_wdata[HEIGHT_REG_W-1:0];
               default: weight_reg[csr_index - CSR_WEIGHT_ROW_0] <= csr_wdata;
            endcase
         end
         if (req_tvalid && req_tready) begin
            convolve_request(req_tuser, req_tdata, produced, res);
            // a typed row states its result outright
            if (cur_typed) pending_results.push_back(cur_result);
            else if (produced) pending_results.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report("unexpected result", rsp_tdata, -1);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.pixel) report("filtered_pixel", rsp_tdata, want.pixel);
               if (rsp_tlast !== want.last) report("frame_last", rsp_tlast, want.last);
            end
         end
      end
   end

   // Watchdog: count cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Result side: stall for a drawn number of cycles before each result
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 14);
         if (n > 0) begin
            rsp_tready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Offer one request after a drawn gap; return at the falling edge after it
   // has been taken. Valid stays high so the next request can follow at once.
   task automatic send_request(input req_mode_type mode, input logic [7:0] pixel,
                               input bit typed, input filtered_t result);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = mode;
      req_tdata = pixel;
      cur_typed = typed;
      cur_result = result;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drain everything, let the pipeline settle, then write one register
   task automatic write_csr(input csr_index_type index, input logic [WREG_W-1:0] value);
      req_tvalid = 1'b0;
      cur_typed = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [WREG_W-1:0] random_weight_row();
      logic [WREG_W-1:0] row;
      for (int j = 0; j < 5; j++)
         row[j*12 +: 12] = 12'($urandom_range(0, 4095) >> $urandom_range(0, 7));
      return row;
   endfunction

   // Queue directed steps
   function automatic void add_csr(csr_index_type index, logic [WREG_W-1:0] value);
      step_t s;
      s = '{is_csr: 1, index: index, value: value, mode: MODE_PIXEL, pixel: '0,
            typed: 0, result: '0};
      directed.push_back(s);
   endfunction

   function automatic void add_req(req_mode_type mode, logic [7:0] pixel, bit typed,
                                   logic [7:0] rpix, bit rlast);
      step_t s;
      s = '{is_csr: 0, index: CSR_KERNEL_SIZE, value: '0, mode: mode, pixel: pixel,
            typed: typed, result: '{pixel: rpix, last: rlast}};
      directed.push_back(s);
   endfunction

   // Run one frame at the given settings: pixels with stray flushes inside,
   // then exactly the flush ticks that release its tail, the odd one sent as
   // a pixel that the block must discard.
   task automatic run_frame(input int k, input int w, input int h, inout int sent);
      int kk, ww, hh, lag;
      write_csr(CSR_KERNEL_SIZE, WREG_W'(k));
      write_csr(CSR_IMAGE_WIDTH, WREG_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, WREG_W'(h));
      for (int r = 0; r < WREG_COUNT; r++)
         if ($urandom_range(0, 2) == 0)
            write_csr(csr_index_type'(CSR_WEIGHT_ROW_0 + r), random_weight_row());
      if ($urandom_range(0, 5) == 0) quiet = ~quiet;
      kk = eff_kernel();
      ww = eff_width();
      hh = eff_height();
      lag = (kk / 2) * ww + kk / 2;
      for (int i = 0; i < ww * hh; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_request(MODE_FLUSH, 8'($urandom), 0, '0);
         send_request(MODE_PIXEL, 8'($urandom), 0, '0);
         sent++;
      end
      for (int i = 0; i < lag; i++) begin
         send_request(($urandom_range(0, 5) == 0) ? MODE_PIXEL : MODE_FLUSH,
                      8'($urandom), 0, '0);
         sent++;
      end
      // spare flushes after the frame are ignored
      if ($urandom_range(0, 3) == 0) send_request(MODE_FLUSH, 8'($urandom), 0, '0);
   endtask

   initial begin
      int sent;
      logic [7:0] frame_a [8];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      quiet = 0;
      cur_typed = 0;
      cur_result = '0;
      sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Identity kernel, 4x2, K=1: every result is its own pixel, no lag
      frame_a = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd127, 8'h55, 8'hAA};
      add_csr(CSR_KERNEL_SIZE, 60'd1);
      add_csr(CSR_IMAGE_WIDTH, 60'd4);
      add_csr(CSR_IMAGE_HEIGHT, 60'd2);
      add_csr(CSR_WEIGHT_ROW_0, 60'd1024);
      for (int i = 0; i < 8; i++) begin
         add_req(MODE_PIXEL, frame_a[i], 1, frame_a[i], i == 7);
         if (i == 3) add_req(MODE_FLUSH, 8'd9, 0, 0, 0);   // stray flush, dropped
      end
      // 5x5 of maximal weights over white pixels saturates; 3x2 frame shorter
      // than the lag, so the tail comes out on the flush ticks alone
      add_csr(CSR_KERNEL_SIZE, 60'd5);
      add_csr(CSR_IMAGE_WIDTH, 60'd3);
      add_csr(CSR_IMAGE_HEIGHT, 60'd2);
      for (int r = 0; r < WREG_COUNT; r++)
         add_csr(csr_index_type'(CSR_WEIGHT_ROW_0 + r), {WREG_W{1'b1}});
      for (int i = 0; i < 6; i++) add_req(MODE_PIXEL, 8'd255, 0, 0, 0);
      for (int i = 0; i < 8; i++)
         add_req((i == 4) ? MODE_PIXEL : MODE_FLUSH, 8'd0, i >= 2, PIXEL_MAX, i == 7);

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            write_csr(directed[i].index, directed[i].value);
         end else begin
            send_request(directed[i].mode, directed[i].pixel, directed[i].typed,
                         directed[i].result);
         end
      end

      // Register extremes: widest row, zero and out-of-range codes
      run_frame(1, 2047, 1, sent);
      run_frame(7, 1, 0, sent);
      run_frame(0, 0, 0, sent);
      while (sent < 1300) begin
         if ($urandom_range(0, 7) == 0)
            run_frame($urandom_range(0, 7), $urandom_range(0, 40), $urandom_range(0, 6), sent);
         else
            run_frame($urandom_range(0, 7), $urandom_range(1, 12), $urandom_range(1, 8), sent);
      end

      req_tvalid = 1'b0;
      cur_typed = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/icrb_pkg.sv
rtl/core/image_convolution_replicate_border_top.sv
tb/image_convolution_replicate_border_top_tb.sv
